// ----- src/msst_pkg.sv -----
// Package for the multi-slot software timer table: field widths, codes and
// the structs passed between the top level and the timer cells.
// No dependencies.
package msst_pkg;

  // Fixed field widths.
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 5;
  localparam int MAX_SLOTS = 16;

  // Parameter defaults for the top level.
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Command opcodes; code 7 means nothing and is acknowledged without effect.
  typedef enum logic [2:0] {
    OP_CREATE      = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_START_ONCE  = 3'd2,
    OP_START_PER   = 3'd3,
    OP_STOP        = 3'd4,
    OP_RESTART     = 3'd5,
    OP_TICK        = 3'd6
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_EXPIRY    = 2'd1,
    KIND_TICK_DONE = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_IN_USE = 2'd2
  } status_e;

  // What the token traveling down the cell row is doing.
  typedef enum logic [1:0] {
    WALK_NONE   = 2'd0,
    WALK_TICK   = 2'd1,
    WALK_EMIT   = 2'd2,
    WALK_CREATE = 2'd3
  } walk_e;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_CMD    = 3'd1,
    S_CREATE = 3'd2,
    S_TICK   = 3'd3,
    S_EMIT   = 3'd4,
    S_ACK    = 3'd5
  } state_e;

  // Single-slot command broadcast to every cell.
  typedef struct packed {
    logic              en;
    op_e               op;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // Status reported by a cell while it holds the token.
  typedef struct packed {
    logic claim;  // a create took this free slot
    logic req;    // an expiry result is waiting to leave this slot
    logic dec;    // a one-shot timer stopped on this tick
  } cell_st_t;

endpackage

// ----- src/multi_slot_software_timer_table_core.sv -----
// Top level of the multi-slot software timer table: stream ports, command
// sequencer, active counter, output register and the row of timer cells.
// Depends on msst_pkg and msst_cell.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | one command or tick (opcode in tuser)
//  m_axis   | out       | acknowledge, expiry or tick-finished result
//
// The next input beat can be taken in the cycle after the last result is loaded.
// An unknown opcode or an unchanged tick is acknowledged without a walk. A create
// walks the token to the first free slot, or to the end of the row when full.
// An advancing tick makes an update walk and then an emit walk before the
// tick-finished result; a stall on the output holds the emit walk in place.
// Reset (synchronous) clears all flags, the active count and the last time.
module multi_slot_software_timer_table_core #(
  parameter int NUM_SLOTS  = msst_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = msst_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: slot[3:0], period[19:4], now_time[51:20], zero pad
  input  logic [55:0] s_axis_tdata,
  // tuser fields from bit 0: opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: status[1:0], result_slot[5:2], active_count[10:6], zero pad
  output logic [15:0] m_axis_tdata,
  // tuser fields from bit 0: kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  // Only sixteen slots can be addressed.
  localparam int CELLS = (NUM_SLOTS < msst_pkg::MAX_SLOTS) ? NUM_SLOTS : msst_pkg::MAX_SLOTS;

  msst_pkg::state_e state, state_next;

  // Latched item and tick bookkeeping.
  msst_pkg::op_e                   op_r;
  logic [msst_pkg::SLOT_W-1:0]     slot_r;
  logic [msst_pkg::PERIOD_W-1:0]   period_r;
  logic [msst_pkg::TIME_W-1:0]     diff_r;
  logic [msst_pkg::TIME_W-1:0]     last_time;
  logic [msst_pkg::CNT_W-1:0]      act_cnt, act_cnt_next;

  // Pending acknowledge fields.
  msst_pkg::kind_e                 ack_kind, ack_kind_next;
  msst_pkg::status_e               ack_status, ack_status_next;
  logic [msst_pkg::SLOT_W-1:0]     ack_slot, ack_slot_next;

  // Output register.
  msst_pkg::kind_e                 out_kind, out_kind_d;
  msst_pkg::status_e               out_status, out_status_d;
  logic [msst_pkg::SLOT_W-1:0]     out_slot, out_slot_d;
  logic [msst_pkg::CNT_W-1:0]      out_cnt, out_cnt_d;
  logic                            out_last, out_last_d;
  logic                            out_load;
  logic                            out_free;

  // Input fields.
  msst_pkg::op_e                   in_op;
  logic [msst_pkg::SLOT_W-1:0]     in_slot;
  logic [msst_pkg::PERIOD_W-1:0]   in_period;
  logic [msst_pkg::TIME_W-1:0]     in_now;
  logic [msst_pkg::TIME_W-1:0]     in_diff;
  logic                            accept;

  // Cell row links.
  msst_pkg::walk_e                 walk;
  msst_pkg::cmd_t                  cmd;
  logic                            inject;
  logic                            grant;
  logic [CELLS-1:0]                tok_out;
  logic [CELLS-1:0]                tok_in;
  logic [CELLS-1:0]                in_use_vec;
  logic [CELLS-1:0]                active_vec;
  msst_pkg::cell_st_t              st [CELLS];
  logic [msst_pkg::MAX_SLOTS-1:0]  in_use16;
  logic [msst_pkg::MAX_SLOTS-1:0]  active16;
  logic                            claim_any, req_any, dec_any;
  logic [msst_pkg::SLOT_W-1:0]     hit_idx;
  logic                            walk_end;
  logic                            slot_ok;
  logic                            slot_act;

  // Unpack the input beat.
  assign in_op     = msst_pkg::op_e'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[3:0];
  assign in_period = s_axis_tdata[19:4];
  assign in_now    = s_axis_tdata[51:20];
  assign in_diff   = in_now - last_time;
  assign s_axis_tready = (state == msst_pkg::S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Pack the output beat.
  assign m_axis_tdata  = {5'b0, out_cnt, out_slot, out_status};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // Row of timer cells; the token moves one cell a cycle unless an emit walk holds it.
  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign tok_in[g] = inject;
      end else begin : g_rest
        assign tok_in[g] = tok_out[g-1];
      end
      msst_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX        (g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .walk    (walk),
        .tok_in  (tok_in[g]),
        .grant   (grant),
        .cmd     (cmd),
        .period  (period_r),
        .diff    (diff_r),
        .tok_out (tok_out[g]),
        .st      (st[g]),
        .in_use  (in_use_vec[g]),
        .active  (active_vec[g])
      );
    end
  endgenerate

  assign walk_end = tok_out[CELLS-1];
  assign in_use16 = msst_pkg::MAX_SLOTS'(in_use_vec);
  assign active16 = msst_pkg::MAX_SLOTS'(active_vec);
  assign slot_ok  = in_use16[slot_r];
  assign slot_act = active16[slot_r];

  // Collect the status of the one cell that holds the token.
  always_comb begin
    claim_any = 1'b0;
    req_any   = 1'b0;
    dec_any   = 1'b0;
    hit_idx   = '0;
    for (int i = 0; i < CELLS; i++) begin
      claim_any = claim_any | st[i].claim;
      req_any   = req_any | st[i].req;
      dec_any   = dec_any | st[i].dec;
      if (st[i].claim || st[i].req) begin
        hit_idx = hit_idx | msst_pkg::SLOT_W'(i);
      end
    end
  end

  // Walk mode and command broadcast follow the state.
  always_comb begin
    case (state)
      msst_pkg::S_CREATE: walk = msst_pkg::WALK_CREATE;
      msst_pkg::S_TICK:   walk = msst_pkg::WALK_TICK;
      msst_pkg::S_EMIT:   walk = msst_pkg::WALK_EMIT;
      default:            walk = msst_pkg::WALK_NONE;
    endcase
    cmd.en   = (state == msst_pkg::S_CMD);
    cmd.op   = op_r;
    cmd.slot = slot_r;
  end

  // Sequencer: next state, token injection, active count and result beats.
  always_comb begin
    state_next      = state;
    inject          = 1'b0;
    grant           = 1'b0;
    act_cnt_next    = act_cnt;
    ack_kind_next   = ack_kind;
    ack_status_next = ack_status;
    ack_slot_next   = ack_slot;
    out_load        = 1'b0;
    out_kind_d      = msst_pkg::KIND_ACK;
    out_status_d    = msst_pkg::STAT_OK;
    out_slot_d      = '0;
    out_cnt_d       = act_cnt;
    out_last_d      = 1'b1;

    case (state)
      msst_pkg::S_IDLE: begin
        if (accept) begin
          ack_kind_next   = msst_pkg::KIND_ACK;
          ack_status_next = msst_pkg::STAT_OK;
          ack_slot_next   = '0;
          case (in_op)
            msst_pkg::OP_CREATE: begin
              inject     = 1'b1;
              state_next = msst_pkg::S_CREATE;
            end
            msst_pkg::OP_TICK: begin
              ack_kind_next = msst_pkg::KIND_TICK_DONE;
              if (in_diff != '0) begin
                inject     = 1'b1;
                state_next = msst_pkg::S_TICK;
              end else begin
                state_next = msst_pkg::S_ACK;
              end
            end
            msst_pkg::OP_REMOVE, msst_pkg::OP_START_ONCE, msst_pkg::OP_START_PER,
            msst_pkg::OP_STOP, msst_pkg::OP_RESTART: begin
              state_next = msst_pkg::S_CMD;
            end
            default: begin
              state_next = msst_pkg::S_ACK;
            end
          endcase
        end
      end

      msst_pkg::S_CMD: begin
        ack_slot_next   = slot_r;
        ack_status_next = slot_ok ? msst_pkg::STAT_OK : msst_pkg::STAT_NOT_IN_USE;
        if (slot_ok) begin
          case (op_r)
            msst_pkg::OP_REMOVE, msst_pkg::OP_STOP: begin
              if (slot_act) begin
                act_cnt_next = act_cnt - 1'b1;
              end
            end
            msst_pkg::OP_START_ONCE, msst_pkg::OP_START_PER: begin
              if (!slot_act) begin
                act_cnt_next = act_cnt + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        state_next = msst_pkg::S_ACK;
      end

      msst_pkg::S_CREATE: begin
        if (claim_any) begin
          ack_status_next = msst_pkg::STAT_OK;
          ack_slot_next   = hit_idx;
          state_next      = msst_pkg::S_ACK;
        end else if (walk_end) begin
          ack_status_next = msst_pkg::STAT_FULL;
          ack_slot_next   = '0;
          state_next      = msst_pkg::S_ACK;
        end
      end

      msst_pkg::S_TICK: begin
        if (dec_any) begin
          act_cnt_next = act_cnt - 1'b1;
        end
        if (walk_end) begin
          inject     = 1'b1;
          state_next = msst_pkg::S_EMIT;
        end
      end

      msst_pkg::S_EMIT: begin
        if (req_any && out_free) begin
          grant        = 1'b1;
          out_load     = 1'b1;
          out_kind_d   = msst_pkg::KIND_EXPIRY;
          out_slot_d   = hit_idx;
          out_last_d   = 1'b0;
        end
        if (walk_end) begin
          state_next = msst_pkg::S_ACK;
        end
      end

      msst_pkg::S_ACK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = ack_kind;
          out_status_d = ack_status;
          out_slot_d   = ack_slot;
          state_next   = msst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = msst_pkg::S_IDLE;
      end
    endcase
  end

  // State, counters and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= msst_pkg::S_IDLE;
      act_cnt       <= '0;
      last_time     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      act_cnt <= act_cnt_next;
      if (accept && (in_op == msst_pkg::OP_TICK) && (in_diff != '0)) begin
        last_time <= in_now;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      slot_r   <= in_slot;
      period_r <= in_period;
      diff_r   <= in_diff;
    end
    ack_kind   <= ack_kind_next;
    ack_status <= ack_status_next;
    ack_slot   <= ack_slot_next;
    if (out_load) begin
      out_kind   <= out_kind_d;
      out_status <= out_status_d;
      out_slot   <= out_slot_d;
      out_cnt    <= out_cnt_d;
      out_last   <= out_last_d;
    end
  end

  // At most one cell passes the token on in any cycle.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_out))
    else $error("more than one cell passes the token");

  // Between items the active counter matches the active slots in use.
  a_act_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == msst_pkg::S_IDLE) |->
      (32'(act_cnt) == $countones(in_use_vec & active_vec)))
    else $error("active counter out of step with the cells");

  // Expiry beats are never last and always report ok.
  a_expiry_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == msst_pkg::KIND_EXPIRY)) |->
      (!m_axis_tlast && (m_axis_tdata[1:0] == msst_pkg::STAT_OK)))
    else $error("malformed expiry beat");

  // A slot is only claimed during a create walk.
  a_claim_walk: assert property (@(posedge clk) disable iff (rst)
    claim_any |-> (state == msst_pkg::S_CREATE))
    else $error("slot claimed outside a create walk");

  // An expiry beat is only loaded while the emit walk holds a requesting cell.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    grant |-> (req_any && (state == msst_pkg::S_EMIT) && out_free))
    else $error("expiry granted without a request");

endmodule

// ----- src/msst_cell.sv -----
// One timer slot of the cell row: flags, period and down counter.
// Depends on msst_pkg; instantiated by multi_slot_software_timer_table_core.
module msst_cell #(
  parameter int COUNT_BITS = msst_pkg::COUNT_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  msst_pkg::walk_e                walk,
  input  logic                           tok_in,
  input  logic                           grant,
  input  msst_pkg::cmd_t                 cmd,
  input  logic [msst_pkg::PERIOD_W-1:0]  period,
  input  logic [msst_pkg::TIME_W-1:0]    diff,
  output logic                           tok_out,
  output msst_pkg::cell_st_t             st,
  output logic                           in_use,
  output logic                           active
);

  // Token and flag registers.
  logic here;
  logic periodic;
  logic pending;
  logic expd;
  logic [COUNT_BITS-1:0] period_q;
  logic [COUNT_BITS-1:0] count_q;

  logic here_next, in_use_next, active_next, periodic_next, pending_next, expd_next;
  logic [COUNT_BITS-1:0] period_next;
  logic [COUNT_BITS-1:0] count_next;

  logic hold;
  logic claim;
  logic sel;
  logic oneshot_fire;
  logic act_mid;
  logic ge;
  logic [msst_pkg::TIME_W-1:0] wide_rem;
  logic [COUNT_BITS-1:0] rem;

  // Token handling and status toward the sequencer.
  always_comb begin
    hold    = (walk == msst_pkg::WALK_EMIT) && expd && !grant;
    claim   = here && (walk == msst_pkg::WALK_CREATE) && !in_use;
    tok_out = here && !hold && !claim;
    st.claim = claim;
    st.req   = here && (walk == msst_pkg::WALK_EMIT) && expd;
    st.dec   = here && (walk == msst_pkg::WALK_TICK) && in_use && pending &&
               !periodic && active;
    sel = cmd.en && (cmd.slot == msst_pkg::SLOT_W'(IDX)) && in_use;
  end

  // Tick arithmetic: counter against the elapsed time.
  always_comb begin
    oneshot_fire = pending && !periodic;
    act_mid  = active && !oneshot_fire;
    ge       = msst_pkg::TIME_W'(count_q) >= diff;
    wide_rem = msst_pkg::TIME_W'(count_q) - diff;
    rem      = COUNT_BITS'(wide_rem);
  end

  // Next state of the slot.
  always_comb begin
    here_next     = tok_in || (here && hold);
    in_use_next   = in_use;
    active_next   = active;
    periodic_next = periodic;
    pending_next  = pending;
    expd_next     = expd;
    period_next   = period_q;
    count_next    = count_q;

    // Tick walk: pending expiry first, then the countdown.
    if (here && (walk == msst_pkg::WALK_TICK) && in_use) begin
      if (pending) begin
        pending_next = 1'b0;
        expd_next    = 1'b1;
        if (!periodic) begin
          active_next = 1'b0;
          count_next  = period_q;
        end
      end
      if (act_mid) begin
        if (ge) begin
          if (rem == '0) begin
            count_next   = period_q;
            pending_next = 1'b1;
          end else begin
            count_next = rem;
          end
        end else begin
          count_next   = '0;
          pending_next = 1'b1;
        end
      end
    end

    // Emit walk: the expiry beat has been taken.
    if (st.req && grant) begin
      expd_next = 1'b0;
    end

    // Create walk: this free slot becomes the new timer.
    if (claim) begin
      in_use_next   = 1'b1;
      active_next   = 1'b0;
      periodic_next = 1'b0;
      pending_next  = 1'b0;
      period_next   = COUNT_BITS'(period);
      count_next    = COUNT_BITS'(period);
    end

    // Commands addressed to this slot.
    if (sel) begin
      case (cmd.op)
        msst_pkg::OP_REMOVE: begin
          in_use_next   = 1'b0;
          active_next   = 1'b0;
          periodic_next = 1'b0;
          pending_next  = 1'b0;
        end
        msst_pkg::OP_START_ONCE: begin
          count_next    = period_q;
          periodic_next = 1'b0;
          active_next   = 1'b1;
        end
        msst_pkg::OP_START_PER: begin
          count_next    = period_q;
          periodic_next = 1'b1;
          active_next   = 1'b1;
        end
        msst_pkg::OP_STOP: begin
          count_next  = period_q;
          active_next = 1'b0;
        end
        msst_pkg::OP_RESTART: begin
          count_next = period_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      here     <= 1'b0;
      in_use   <= 1'b0;
      active   <= 1'b0;
      periodic <= 1'b0;
      pending  <= 1'b0;
      expd     <= 1'b0;
    end else begin
      here     <= here_next;
      in_use   <= in_use_next;
      active   <= active_next;
      periodic <= periodic_next;
      pending  <= pending_next;
      expd     <= expd_next;
    end
  end

  // Period and counter hold no reset; they are written by create first.
  always_ff @(posedge clk) begin
    period_q <= period_next;
    count_q  <= count_next;
  end

endmodule

// ----- tb/msst_checker.sv -----
// Checker for the multi-slot software timer table: watches both stream ports,
// predicts every result beat from the accepted command and tick beats and compares.
// Depends on msst_pkg.
module msst_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata fields from bit 0: slot[3:0], period[19:4], now_time[51:20], zero pad
  input  logic [55:0] s_axis_tdata,
  // tuser fields from bit 0: opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: status[1:0], result_slot[5:2], active_count[10:6], zero pad
  input  logic [15:0] m_axis_tdata,
  // tuser fields from bit 0: kind[1:0]
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = (msst_pkg::NUM_SLOTS_DEF < msst_pkg::MAX_SLOTS) ?
                         msst_pkg::NUM_SLOTS_DEF : msst_pkg::MAX_SLOTS;

  typedef struct {
    msst_pkg::kind_e             kind;
    msst_pkg::status_e           status;
    logic [msst_pkg::SLOT_W-1:0] slot;
    logic [msst_pkg::CNT_W-1:0]  active;
    logic                        last;
  } timer_result_t;

  // Shadow copy of the timer table.
  logic                          in_use   [msst_pkg::MAX_SLOTS];
  logic                          running  [msst_pkg::MAX_SLOTS];
  logic                          periodic [msst_pkg::MAX_SLOTS];
  logic                          pending  [msst_pkg::MAX_SLOTS];
  logic [msst_pkg::PERIOD_W-1:0] period_q [msst_pkg::MAX_SLOTS];
  logic [msst_pkg::PERIOD_W-1:0] count_q  [msst_pkg::MAX_SLOTS];
  logic [msst_pkg::TIME_W-1:0]   last_time;

  timer_result_t expected_results[$];

  function automatic logic [msst_pkg::CNT_W-1:0] running_timers();
    logic [msst_pkg::CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (in_use[i] && running[i]) n++;
    end
    return n;
  endfunction

  function automatic timer_result_t make_result(msst_pkg::kind_e k, msst_pkg::status_e st,
                                                logic [msst_pkg::SLOT_W-1:0] sl, logic lst);
    timer_result_t r;
    r.kind   = k;
    r.status = st;
    r.slot   = sl;
    r.active = '0;
    r.last   = lst;
    return r;
  endfunction

  // Advance the shadow table by one tick and queue its expiries and the closing beat.
  task automatic predict_tick(input logic [msst_pkg::TIME_W-1:0] now);
    logic [msst_pkg::TIME_W-1:0] elapsed;
    timer_result_t               batch[$];
    timer_result_t               r;
    logic [msst_pkg::CNT_W-1:0]  act;
    elapsed = now - last_time;
    if (elapsed != 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (in_use[i]) begin
          // An expiry marked on the previous tick leaves now.
          if (pending[i]) begin
            pending[i] = 1'b0;
            if (!periodic[i]) begin
              running[i] = 1'b0;
              count_q[i] = period_q[i];
            end
            batch.push_back(make_result(msst_pkg::KIND_EXPIRY, msst_pkg::STAT_OK,
                                        msst_pkg::SLOT_W'(i), 1'b0));
          end
          // Count down; reaching or passing zero marks the slot pending.
          if (running[i]) begin
            if (msst_pkg::TIME_W'(count_q[i]) >= elapsed) begin
              count_q[i] = count_q[i] - elapsed[msst_pkg::PERIOD_W-1:0];
              if (count_q[i] == 0) begin
                count_q[i] = period_q[i];
                pending[i] = 1'b1;
              end
            end else begin
              count_q[i] = '0;
              pending[i] = 1'b1;
            end
          end
        end
      end
      last_time = now;
    end
    act = running_timers();
    batch.push_back(make_result(msst_pkg::KIND_TICK_DONE, msst_pkg::STAT_OK, '0, 1'b1));
    foreach (batch[j]) begin
      r = batch[j];
      r.active = act;
      expected_results.push_back(r);
    end
  endtask

  // Apply one command to the shadow table and queue its acknowledge.
  task automatic predict_command(input logic [2:0] op,
                                 input logic [msst_pkg::SLOT_W-1:0] sl,
                                 input logic [msst_pkg::PERIOD_W-1:0] per);
    msst_pkg::status_e           st;
    logic [msst_pkg::SLOT_W-1:0] rs;
    logic                        hit;
    int                          free;
    timer_result_t               r;
    st  = msst_pkg::STAT_OK;
    rs  = sl;
    hit = (int'(sl) < SLOTS) && in_use[sl];
    if (op == msst_pkg::OP_CREATE) begin
      free = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!in_use[i]) free = i;
      end
      if (free < 0) begin
        st = msst_pkg::STAT_FULL;
        rs = '0;
      end else begin
        in_use[free]   = 1'b1;
        period_q[free] = per;
        count_q[free]  = per;
        running[free]  = 1'b0;
        periodic[free] = 1'b0;
        pending[free]  = 1'b0;
        rs = msst_pkg::SLOT_W'(free);
      end
    end else if (op >= msst_pkg::OP_REMOVE && op <= msst_pkg::OP_RESTART) begin
      if (!hit) begin
        st = msst_pkg::STAT_NOT_IN_USE;
      end else begin
        case (op)
          msst_pkg::OP_REMOVE: begin
            in_use[sl]   = 1'b0;
            running[sl]  = 1'b0;
            periodic[sl] = 1'b0;
            pending[sl]  = 1'b0;
          end
          msst_pkg::OP_START_ONCE: begin
            count_q[sl]  = period_q[sl];
            periodic[sl] = 1'b0;
            running[sl]  = 1'b1;
          end
          msst_pkg::OP_START_PER: begin
            count_q[sl]  = period_q[sl];
            periodic[sl] = 1'b1;
            running[sl]  = 1'b1;
          end
          msst_pkg::OP_STOP: begin
            // The pending flag survives a stop.
            count_q[sl] = period_q[sl];
            running[sl] = 1'b0;
          end
          default: begin
            count_q[sl] = period_q[sl];
          end
        endcase
      end
    end else begin
      // An opcode with no meaning is acknowledged without effect.
      rs = '0;
    end
    r = make_result(msst_pkg::KIND_ACK, st, rs, 1'b1);
    r.active = running_timers();
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted input beat, compare on every accepted result beat.
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      for (int i = 0; i < msst_pkg::MAX_SLOTS; i++) begin
        in_use[i]   = 1'b0;
        running[i]  = 1'b0;
        periodic[i] = 1'b0;
        pending[i]  = 1'b0;
        period_q[i] = '0;
        count_q[i]  = '0;
      end
      last_time = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == msst_pkg::OP_TICK) begin
          predict_tick(s_axis_tdata[51:20]);
        end else begin
          predict_command(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation: kind %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("result_slot", want.slot, m_axis_tdata[5:2]);
          check_field("active_count", want.active, m_axis_tdata[10:6]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the timer table testbench: clock, reset, command and tick stimulus,
// output back-pressure and the verdict. Depends on msst_pkg, msst_checker and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam int         RANDOM_BEATS = 52;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        s_fire = 1'b0;
  int          mismatches;
  int          outstanding;

  int          send_idle_pct = 12;
  int          recv_idle_pct = 88;
  logic [31:0] now_time = '0;
  logic        slot_used [msst_pkg::MAX_SLOTS];
  int          random_sent;

  multi_slot_software_timer_table_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  msst_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remember whether the input beat was taken at the last rising edge.
  always @(posedge clk) begin
    s_fire <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // Random back-pressure on the result stream.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one beat after a random gap and hold it until it is taken.
  task automatic send_beat(input logic [2:0] op, input logic [3:0] slot,
                           input logic [15:0] per, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, now, per, slot};
    @(negedge clk);
    while (!s_fire) @(negedge clk);
    // Track which slots hold a timer so most commands can hit one.
    if (op == msst_pkg::OP_CREATE) begin
      for (int i = 0; i < msst_pkg::MAX_SLOTS; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          break;
        end
      end
    end else if (op == msst_pkg::OP_REMOVE) begin
      slot_used[slot] = 1'b0;
    end
  endtask

  task automatic tick_at(input logic [31:0] t);
    now_time = t;
    send_beat(msst_pkg::OP_TICK, 4'($urandom_range(15)), 16'($urandom), t);
  endtask

  function automatic logic [15:0] rand_period();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(12));
    if (r < 85) return 16'($urandom_range(200, 13));
    return 16'($urandom);
  endfunction

  // Mostly a slot that holds a timer, sometimes any slot at all.
  function automatic logic [3:0] pick_slot();
    int start;
    start = $urandom_range(15);
    if ($urandom_range(99) < 85) begin
      for (int i = 0; i < msst_pkg::MAX_SLOTS; i++) begin
        if (slot_used[(start + i) % msst_pkg::MAX_SLOTS]) begin
          return 4'((start + i) % msst_pkg::MAX_SLOTS);
        end
      end
    end
    return 4'(start);
  endfunction

  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(99);
    if (r < 15) return now_time;
    if (r < 70) return now_time + $urandom_range(8, 1);
    if (r < 85) return now_time + $urandom_range(300, 9);
    if (r < 95) return now_time + $urandom_range(70000, 1000);
    return $urandom;
  endfunction

  task automatic random_round();
    int kind;
    int n;
    logic [2:0] op;
    kind = $urandom_range(99);
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      if (kind < 20) begin
        send_beat(msst_pkg::OP_CREATE, 4'($urandom_range(15)), rand_period(), $urandom);
      end else if (kind < 45) begin
        op = ($urandom_range(1)) ? msst_pkg::OP_START_PER : msst_pkg::OP_START_ONCE;
        send_beat(op, pick_slot(), 16'($urandom), $urandom);
      end else if (kind < 75) begin
        tick_at(next_time());
      end else if (kind < 90) begin
        case ($urandom_range(2))
          0: op = msst_pkg::OP_STOP;
          1: op = msst_pkg::OP_RESTART;
          default: op = msst_pkg::OP_REMOVE;
        endcase
        send_beat(op, pick_slot(), 16'($urandom), $urandom);
      end else begin
        // Noise: any opcode with any fields.
        send_beat(3'($urandom_range(7)), 4'($urandom_range(15)), 16'($urandom), $urandom);
      end
      random_sent++;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Main stimulus.
  initial begin
    for (int i = 0; i < msst_pkg::MAX_SLOTS; i++) slot_used[i] = 1'b0;
    random_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unchanged time, field extremes, zero period, missing slots,
    // stop while pending, restart, huge steps and time wrap.
    tick_at(32'h0);
    send_beat(msst_pkg::OP_CREATE, 4'hF, 16'h0000, 32'hFFFF_FFFF);
    send_beat(msst_pkg::OP_CREATE, 4'h0, 16'hFFFF, 32'h0);
    send_beat(msst_pkg::OP_CREATE, 4'h5, 16'd3, 32'h0);
    send_beat(msst_pkg::OP_CREATE, 4'hA, 16'd5, 32'h0);
    send_beat(OP_UNUSED, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(msst_pkg::OP_REMOVE, 4'd9, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_START_ONCE, 4'hF, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_START_PER, 4'd0, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_START_ONCE, 4'd2, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_START_PER, 4'd3, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_START_ONCE, 4'd1, 16'h0, 32'h0);
    tick_at(32'd3);
    send_beat(msst_pkg::OP_STOP, 4'd0, 16'h0, 32'h0);
    tick_at(32'd3);
    tick_at(32'd10);
    send_beat(msst_pkg::OP_RESTART, 4'd3, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_STOP, 4'd8, 16'h0, 32'h0);
    send_beat(msst_pkg::OP_RESTART, 4'd12, 16'h0, 32'h0);
    tick_at(32'hFFFF_FFF0);
    tick_at(32'h0000_0004);
    send_beat(msst_pkg::OP_REMOVE, 4'd1, 16'h0, 32'h0);

    // Fill the table and ask for one slot too many.
    for (int i = 0; i < 14; i++) begin
      send_beat(msst_pkg::OP_CREATE, 4'($urandom_range(15)), rand_period(), $urandom);
    end
    for (int i = 0; i < 6; i++) begin
      send_beat(msst_pkg::OP_START_PER, pick_slot(), 16'h0, 32'h0);
      tick_at(next_time());
    end

    // Random rounds over three idling profiles; the sender waits for a full
    // drain at each change of profile.
    while (random_sent < RANDOM_BEATS) begin
      if (random_sent >= 17 && send_idle_pct == 12) begin
        wait_drained();
        send_idle_pct = 88;
        recv_idle_pct = 12;
      end else if (random_sent >= 35 && send_idle_pct == 88) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_round();
    end

    // Drain and let the block settle.
    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
